FILE: rtl/pidm_pkg.sv
// ----------------------------------------------------------------------------
// pidm_pkg
// Shared types and constants of the PID motor speed controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pidm_pkg;

  // Field widths
  localparam int SPEED_W = 16;
  localparam int GAIN_W  = 16;
  localparam int LIMIT_W = 16;
  localparam int ERR_W   = SPEED_W + 1;   // target - measured
  localparam int DELTA_W = ERR_W + 1;     // err - previous err
  localparam int PKP_W   = GAIN_W + 1 + ERR_W;
  localparam int PKD_W   = GAIN_W + 1 + DELTA_W;
  localparam int ACC_W   = PKD_W + 1;     // sum of the three terms
  localparam int DRIVE_W = LIMIT_W + 1;
  localparam int PINS_W  = 2;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUM_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = 3'd4;

  // Register reset values
  localparam logic [GAIN_W-1:0]  KP_RESET    = 16'd24576;
  localparam logic [GAIN_W-1:0]  KI_RESET    = 16'd492;
  localparam logic [GAIN_W-1:0]  KD_RESET    = 16'd6554;
  localparam logic [LIMIT_W-1:0] SUM_LIM_RESET = 16'd10000;
  localparam logic [LIMIT_W-1:0] OUT_LIM_RESET = 16'd10000;

  // H-bridge pin codes
  localparam logic [PINS_W-1:0] PINS_COAST = 2'd0;
  localparam logic [PINS_W-1:0] PINS_DIR1  = 2'd1;
  localparam logic [PINS_W-1:0] PINS_DIR2  = 2'd2;

  // Per-channel controller state
  typedef struct packed {
    logic signed [ERR_W-1:0] esum;
    logic signed [ERR_W-1:0] perr;
  } state_t;

  // Item after the error subtract
  typedef struct packed {
    logic                    ch;
    logic                    tz;    // target is zero
    logic signed [ERR_W-1:0] err;
  } item_t;

endpackage

`default_nettype wire

FILE: rtl/pidm_state_mem.sv
// ----------------------------------------------------------------------------
// pidm_state_mem
// Per-channel state memory, one read and one write port, registered read,
// with forwarding of the most recent write.
// ----------------------------------------------------------------------------
`default_nettype none

module pidm_state_mem
  import pidm_pkg::*;
#(
  parameter int CHANNELS = 2,
  parameter int IDX_W    = 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_idx,
  output state_t                rd_data,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_idx,
  input  state_t                wr_data
);

  state_t             mem [CHANNELS];
  logic [CHANNELS-1:0] vld_r;
  state_t             rd_data_r;
  logic               rd_vld_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               fwd_v_r;
  logic [IDX_W-1:0]   fwd_idx_r;
  state_t             fwd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // Read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
      rd_idx_r  <= rd_idx;
    end
  end

  // Entry valid bits; an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_idx];
      end
    end
  end

  // Hold the latest write for a read that raced it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r <= 1'b0;
    end else if (wr_en) begin
      fwd_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_idx_r  <= wr_idx;
      fwd_data_r <= wr_data;
    end
  end

  // Select forwarded, stored or reset value
  always_comb begin
    if (fwd_v_r && (fwd_idx_r == rd_idx_r)) begin
      rd_data = fwd_data_r;
    end else if (rd_vld_r) begin
      rd_data = rd_data_r;
    end else begin
      rd_data = '0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pidm_update.sv
// ----------------------------------------------------------------------------
// pidm_update
// Integral update: clamps the new error sum, forms the error change and
// builds the state written back for the channel.
// ----------------------------------------------------------------------------
`default_nettype none

module pidm_update
  import pidm_pkg::*;
(
  input  item_t                       item,
  input  state_t                      st,
  input  wire logic [LIMIT_W-1:0]     sum_limit,
  output logic signed [ERR_W-1:0]     sum,
  output logic signed [DELTA_W-1:0]   delta,
  output state_t                      st_new
);

  logic signed [DELTA_W-1:0] sum_raw;
  logic signed [DELTA_W-1:0] lim;

  // Accumulate and clamp symmetrically
  always_comb begin
    sum_raw = DELTA_W'(st.esum) + DELTA_W'(item.err);
    lim     = $signed({2'b00, sum_limit});
    if (sum_raw > lim) begin
      sum = ERR_W'(lim);
    end else if (sum_raw < -lim) begin
      sum = ERR_W'(-lim);
    end else begin
      sum = ERR_W'(sum_raw);
    end
  end

  // Derivative term input
  assign delta = DELTA_W'(item.err) - DELTA_W'(st.perr);

  // Clear the sum on a zero target
  always_comb begin
    st_new.esum = item.tz ? '0 : sum;
    st_new.perr = item.err;
  end

endmodule

`default_nettype wire

FILE: rtl/pidm_law.sv
// ----------------------------------------------------------------------------
// pidm_law
// Control law pipeline: gain multiplies, sum with truncation toward zero,
// output clamp and pin mapping into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pidm_law
  import pidm_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     law_valid,
  output logic                          law_ready,
  input  item_t                         item,
  input  wire logic signed [ERR_W-1:0]  sum,
  input  wire logic signed [DELTA_W-1:0] delta,
  input  wire logic [GAIN_W-1:0]        kp_gain,
  input  wire logic [GAIN_W-1:0]        ki_gain,
  input  wire logic [GAIN_W-1:0]        kd_gain,
  input  wire logic [LIMIT_W-1:0]       output_limit,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          out_channel,
  output logic [LIMIT_W-1:0]            out_duty,
  output logic [PINS_W-1:0]             out_bridge_pins,
  output logic signed [DRIVE_W-1:0]     out_drive_signed
);

  localparam logic signed [ACC_W-1:0] BIAS =
    ACC_W'((64'(1) << GAIN_FRAC_BITS) - 64'(1));

  logic                       s2_v_r, s2_v_nxt;
  logic                       s3_v_r, s3_v_nxt;
  logic                       out_v_r, out_v_nxt;
  logic                       s2_load, s3_load, out_load;

  logic                       s2_ch_r, s2_tz_r;
  logic signed [PKP_W-1:0]    s2_pkp_r, s2_pki_r;
  logic signed [PKD_W-1:0]    s2_pkd_r;

  logic                       s3_ch_r, s3_tz_r;
  logic signed [ACC_W-1:0]    s3_q_r;
  logic signed [ACC_W-1:0]    acc, acc_b, quo;

  logic signed [ACC_W-1:0]    lim;
  logic signed [ACC_W-1:0]    drv_w;
  logic signed [DRIVE_W-1:0]  drv;
  logic [LIMIT_W-1:0]         duty;
  logic [PINS_W-1:0]          pins;

  // Stage handshake: a stage loads when empty or when it drains
  always_comb begin
    out_load  = !out_v_r || !out_stall;
    s3_load   = !s3_v_r || out_load;
    s2_load   = !s2_v_r || s3_load;
    law_ready = s2_load;
    s2_v_nxt  = s2_load  ? law_valid : s2_v_r;
    s3_v_nxt  = s3_load  ? s2_v_r    : s3_v_r;
    out_v_nxt = out_load ? s3_v_r    : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s2_v_r  <= s2_v_nxt;
      s3_v_r  <= s3_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Multiply stage: three independent gain products
  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_ch_r  <= item.ch;
      s2_tz_r  <= item.tz;
      s2_pkp_r <= $signed({1'b0, kp_gain}) * item.err;
      s2_pki_r <= $signed({1'b0, ki_gain}) * sum;
      s2_pkd_r <= $signed({1'b0, kd_gain}) * delta;
    end
  end

  // Add the terms and scale, truncating toward zero
  always_comb begin
    acc   = ACC_W'(s2_pkp_r) + ACC_W'(s2_pki_r) + ACC_W'(s2_pkd_r);
    acc_b = acc;
    if (acc[ACC_W-1]) begin
      acc_b = acc + BIAS;
    end
    quo = acc_b >>> GAIN_FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (s3_load) begin
      s3_ch_r <= s2_ch_r;
      s3_tz_r <= s2_tz_r;
      s3_q_r  <= quo;
    end
  end

  // Clamp the output and map the bridge pins
  always_comb begin
    lim = $signed({{(ACC_W-LIMIT_W){1'b0}}, output_limit});
    if (s3_q_r > lim) begin
      drv_w = lim;
    end else if (s3_q_r < -lim) begin
      drv_w = -lim;
    end else begin
      drv_w = s3_q_r;
    end
    drv  = DRIVE_W'(drv_w);
    duty = drv[DRIVE_W-1] ? LIMIT_W'(-drv) : LIMIT_W'(drv);
    if (s3_tz_r || (drv == '0)) begin
      pins = PINS_COAST;
    end else if (drv[DRIVE_W-1]) begin
      pins = s3_ch_r ? PINS_DIR2 : PINS_DIR1;
    end else begin
      pins = s3_ch_r ? PINS_DIR1 : PINS_DIR2;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_channel      <= s3_ch_r;
      out_duty         <= duty;
      out_bridge_pins  <= pins;
      out_drive_signed <= drv;
    end
  end

  assign out_valid = out_v_r;

endmodule

`default_nettype wire

FILE: rtl/pid_motor_speed_controller.sv
// ----------------------------------------------------------------------------
// pid_motor_speed_controller
// Positional PID speed controller with integral clamp for several motors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one control tick per transfer with
//   the motor index, target speed and measured speed.
//   Result channel (out_valid / out_stall): one result per tick, in order,
//   with the clamped signed drive, its magnitude as duty and the H-bridge
//   pin pair (mirrored on odd channels, coast on a zero target or zero drive).
//   Configuration channel (cfg_valid / cfg_ready): gains and limits, to be
//   written by the user only while the block is idle, which the block does
//   not enforce; cfg_ready is always high.
//   Pipeline: state read at the input transfer, then multiply, scale, and
//   clamp into the result register.
//   Throughput: one item per cycle while the result is not stalled.
//   Per-channel state sits in a small memory read at the input transfer
//   and written back as the item leaves the read stage; the latest write
//   is forwarded, so ticks for the same motor may follow back to back.
//   Reset clears all per-channel state and loads the default gains.
//   A stalled receiver holds the result; items keep flowing into empty
//   pipeline stages, and in_stall rises only once every stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_motor_speed_controller
  import pidm_pkg::*;
#(
  parameter int CHANNELS       = 2,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      in_channel,
  input  wire logic signed [SPEED_W-1:0] in_target_speed,
  input  wire logic signed [SPEED_W-1:0] in_measured_speed,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_channel,
  output logic [LIMIT_W-1:0]             out_duty,
  output logic [PINS_W-1:0]              out_bridge_pins,
  output logic signed [DRIVE_W-1:0]      out_drive_signed,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [GAIN_W-1:0]         cfg_data
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [GAIN_W-1:0]  kp_r, ki_r, kd_r;
  logic [LIMIT_W-1:0] sum_lim_r, out_lim_r;

  logic               s1_v_r, s1_v_nxt;
  logic               s1_load;
  logic               in_xfer;
  logic               law_ready;
  item_t              in_item;
  item_t              s1_item_r;
  logic [IDX_W-1:0]   in_idx;
  logic [IDX_W-1:0]   s1_idx_r;
  logic               wr_en;
  state_t             st_rd;
  state_t             st_new;
  logic signed [ERR_W-1:0]   sum;
  logic signed [DELTA_W-1:0] delta;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r      <= KP_RESET;
      ki_r      <= KI_RESET;
      kd_r      <= KD_RESET;
      sum_lim_r <= SUM_LIM_RESET;
      out_lim_r <= OUT_LIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KP_GAIN:      kp_r      <= cfg_data;
        REG_KI_GAIN:      ki_r      <= cfg_data;
        REG_KD_GAIN:      kd_r      <= cfg_data;
        REG_SUM_LIMIT:    sum_lim_r <= cfg_data;
        REG_OUTPUT_LIMIT: out_lim_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Form the error and the state index
  always_comb begin
    in_item.ch  = in_channel;
    in_item.tz  = (in_target_speed == '0);
    in_item.err = ERR_W'(in_target_speed) - ERR_W'(in_measured_speed);
    in_idx      = (CHANNELS > 1) ? IDX_W'(in_channel) : '0;
  end

  // Read stage handshake
  always_comb begin
    s1_load  = !s1_v_r || law_ready;
    in_stall = !s1_load;
    in_xfer  = in_valid && s1_load;
    s1_v_nxt = s1_load ? in_valid : s1_v_r;
    wr_en    = s1_v_r && law_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_item_r <= in_item;
      s1_idx_r  <= in_idx;
    end
  end

  // Per-channel state
  pidm_state_mem #(
    .CHANNELS (CHANNELS),
    .IDX_W    (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_xfer),
    .rd_idx  (in_idx),
    .rd_data (st_rd),
    .wr_en   (wr_en),
    .wr_idx  (s1_idx_r),
    .wr_data (st_new)
  );

  // Integral and derivative update, written back as the item advances
  pidm_update u_update (
    .item      (s1_item_r),
    .st        (st_rd),
    .sum_limit (sum_lim_r),
    .sum       (sum),
    .delta     (delta),
    .st_new    (st_new)
  );

  // Control law and result register
  pidm_law #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_law (
    .clk              (clk),
    .rst_n            (rst_n),
    .law_valid        (s1_v_r),
    .law_ready        (law_ready),
    .item             (s1_item_r),
    .sum              (sum),
    .delta            (delta),
    .kp_gain          (kp_r),
    .ki_gain          (ki_r),
    .kd_gain          (kd_r),
    .output_limit     (out_lim_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_channel      (out_channel),
    .out_duty         (out_duty),
    .out_bridge_pins  (out_bridge_pins),
    .out_drive_signed (out_drive_signed)
  );

endmodule

`default_nettype wire
